/* src/plst_pkg.sv */
// Shared types and constants for the positional list store.
package plst_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_W  = 2;
    localparam int POS_W  = 5;
    localparam int WORD_W = 32;
    localparam int LEN_W  = 5;

    localparam int S_TDATA_W = 40;  // position + value, padded to bytes
    localparam int M_TDATA_W = 40;  // read_data + length, padded to bytes

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic             ins;   // committed insert
        logic             rem;   // committed remove
        logic [POS_W-1:0] pos;
    } plst_ctl_t;

endpackage

/* src/plst_cell.sv */
// One storage cell of the list: holds an entry and shifts to/from its neighbors.
module plst_cell
    import plst_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int CELL_IDX   = 0
) (
    input  logic                  aclk,
    input  plst_ctl_t             ctl,
    input  logic [DATA_WIDTH-1:0] value_in,
    input  logic [DATA_WIDTH-1:0] left_in,
    input  logic [DATA_WIDTH-1:0] right_in,
    output logic [DATA_WIDTH-1:0] entry_out,
    output logic [DATA_WIDTH-1:0] rd_out
);

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;
    logic                  at_pos;
    logic                  above_pos;

    assign at_pos    = (32'(ctl.pos) == 32'(CELL_IDX));
    assign above_pos = (32'(CELL_IDX) > 32'(ctl.pos));

    always_comb begin
        entry_next = entry_reg;
        if (ctl.ins && above_pos) begin
            entry_next = left_in;
        end else if (ctl.ins && at_pos) begin
            entry_next = value_in;
        end else if (ctl.rem && (above_pos || at_pos)) begin
            entry_next = right_in;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;
    assign rd_out    = at_pos ? entry_reg : '0;

endmodule

/* src/positional_list_store_top.sv */
// Top level of the positional list store: request decode, count and result register.
//
// A bounded ordered list of DEPTH signed words held in a row of register cells.
// Each request (insert, remove, read, clear) is applied to all cells at once: the
// cells shift all later entries up or down together, so one request can be taken
// every cycle while the output drains; its result is registered. Results wait in
// a single output register; a new request is taken while that register is empty
// or being drained. Failed requests (out-of-range position, insert when full)
// leave the list unchanged and report ok = 0. No clearing pass after reset.
module positional_list_store_top
    import plst_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position[4:0], value[36:5], zero pad
    input  logic [REQ_W-1:0]     s_tuser,   // req_type[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // read_data[31:0], length[36:32], zero pad
    output logic                 m_tuser    // ok[0]
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [REQ_W-1:0]      req_type;
    logic [POS_W-1:0]      position;
    logic [WORD_W-1:0]     value;
    logic                  accept;
    logic [CMP_W-1:0]      pos_x;
    logic [CMP_W-1:0]      cnt_x;
    logic                  full;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  rd_ok;
    logic                  req_ok;
    plst_ctl_t             ctl;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic                  ok_reg;
    logic [WORD_W-1:0]     rd_data_reg;
    logic [LEN_W-1:0]      len_reg;

    logic [DATA_WIDTH-1:0] cell_q  [DEPTH];
    logic [DATA_WIDTH-1:0] cell_rd [DEPTH];
    logic [DATA_WIDTH-1:0] rd_sel;
    logic [WORD_W-1:0]     rd_word;
    logic [DATA_WIDTH-1:0] value_st;

    assign req_type = s_tuser;
    assign position = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W+WORD_W-1:POS_W];

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign pos_x = CMP_W'(position);
    assign cnt_x = CMP_W'(count_reg);
    assign full  = (count_reg == CNT_W'(DEPTH));

    assign ins_ok = (req_type == REQ_INSERT) && !full && (pos_x <= cnt_x);
    assign rem_ok = (req_type == REQ_REMOVE) && (pos_x < cnt_x);
    assign rd_ok  = (req_type == REQ_READ) && (pos_x < cnt_x);

    always_comb begin
        case (req_type)
            REQ_INSERT: req_ok = ins_ok;
            REQ_REMOVE: req_ok = rem_ok;
            REQ_READ:   req_ok = rd_ok;
            REQ_CLEAR:  req_ok = 1'b1;
            default:    req_ok = 1'b0;
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (req_type == REQ_CLEAR) begin
            count_next = '0;
        end else if (ins_ok) begin
            count_next = count_reg + CNT_W'(1);
        end else if (rem_ok) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign ctl.ins = accept && ins_ok;
    assign ctl.rem = accept && rem_ok;
    assign ctl.pos = position;

    assign value_st = DATA_WIDTH'(value);

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] left_d;
            logic [DATA_WIDTH-1:0] right_d;
            if (gi == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_mid_l
                assign left_d = cell_q[gi-1];
            end
            if (gi == DEPTH - 1) begin : g_last
                assign right_d = '0;
            end else begin : g_mid_r
                assign right_d = cell_q[gi+1];
            end
            plst_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CELL_IDX   (gi)
            ) u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .value_in  (value_st),
                .left_in   (left_d),
                .right_in  (right_d),
                .entry_out (cell_q[gi]),
                .rd_out    (cell_rd[gi])
            );
        end
    endgenerate

    always_comb begin
        rd_sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_sel = rd_sel | cell_rd[i];
        end
    end

    generate
        if (DATA_WIDTH >= WORD_W) begin : g_rd_trunc
            assign rd_word = rd_sel[WORD_W-1:0];
        end else begin : g_rd_sext
            assign rd_word = {{(WORD_W - DATA_WIDTH){rd_sel[DATA_WIDTH-1]}}, rd_sel};
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ok_reg      <= req_ok;
            rd_data_reg <= rd_ok ? rd_word : '0;
            len_reg     <= LEN_W'(count_next);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - LEN_W){1'b0}}, len_reg, rd_data_reg};

endmodule

/* sim/tb_positional_list_store_top.sv */
// Self-checking testbench for positional_list_store_top: directed table, then random requests.
`timescale 1ns / 1ps

module tb_positional_list_store_top;
    import plst_pkg::*;

    localparam int LIST_DEPTH     = DEPTH_DEF;
    localparam int RANDOM_ITEMS   = 1800;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PAD_W          = S_TDATA_W - POS_W - WORD_W;

    typedef struct packed {
        logic              ok;
        logic [WORD_W-1:0] read_data;
        logic [LEN_W-1:0]  length;
    } list_result_t;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        logic [WORD_W-1:0] value;
        logic              typed;
        list_result_t      result;
    } request_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // typed expectation that travels with the request on the bus
    logic                 req_typed        = 1'b0;
    list_result_t         req_typed_result = '0;

    // predictor state
    logic [WORD_W-1:0]    list_words [LIST_DEPTH];
    logic [LEN_W-1:0]     list_len = '0;
    list_result_t         expected_results [$];

    request_row_t         directed_rows [$];
    int                   mismatch_count = 0;
    int                   idle_pct       = 9;
    bit                   hold_off_go    = 1'b0;
    bit                   hold_off_done  = 1'b0;
    int                   hold_left      = 0;
    int                   quiet_cycles   = 0;

    always #2 aclk = ~aclk;

    positional_list_store_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    function automatic list_result_t apply_request(input logic [REQ_W-1:0] kind,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] word);
        list_result_t r;
        int i;
        r = '0;
        case (kind)
            REQ_INSERT: begin
                if (list_len < LIST_DEPTH && pos <= list_len) begin
                    for (i = int'(list_len); i > int'(pos); i--)
                        list_words[i] = list_words[i-1];
                    list_words[pos] = word;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            REQ_REMOVE: begin
                if (pos < list_len) begin
                    for (i = int'(pos); i + 1 < int'(list_len); i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            REQ_READ: begin
                if (pos < list_len) begin
                    r.read_data = list_words[pos];
                    r.ok = 1'b1;
                end
            end
            REQ_CLEAR: begin
                list_len = '0;
                r.ok = 1'b1;
            end
        endcase
        r.length = list_len;
        return r;
    endfunction

    // result checker and request predictor
    always @(posedge aclk) begin
        list_result_t got;
        list_result_t want;
        list_result_t predicted;
        if (!aresetn) begin
            list_len = '0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.ok        = m_tuser;
                got.read_data = m_tdata[WORD_W-1:0];
                got.length    = m_tdata[WORD_W +: LEN_W];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result: ok=%0b data=%h len=%0d",
                                 got.ok, got.read_data, got.length);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp ok=%0b data=%h len=%0d, ",
                                      "got ok=%0b data=%h len=%0d"},
                                     want.ok, want.read_data, want.length,
                                     got.ok, got.read_data, got.length);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                predicted = apply_request(s_tuser, s_tdata[POS_W-1:0], s_tdata[POS_W +: WORD_W]);
                expected_results.push_back(req_typed ? req_typed_result : predicted);
            end
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1'b1;
            hold_left     = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                                input logic [WORD_W-1:0] value, input logic typed,
                                input list_result_t result);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid         <= 1'b1;
        s_tuser          <= kind;
        s_tdata          <= {{PAD_W{1'b0}}, value, pos};
        req_typed        <= typed;
        req_typed_result <= result;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [REQ_W-1:0] kind;
        logic [POS_W-1:0] pos;
        int roll;
        int phase;
        int n;

        // typed rows: after reset, extremes, full store and range failures
        directed_rows.push_back('{REQ_READ,   5'd0,  32'h0,         1'b1, '{1'b0, 32'h0, 5'd0}});
        directed_rows.push_back('{REQ_INSERT, 5'd1,  32'h1234_5678, 1'b1, '{1'b0, 32'h0, 5'd0}});
        directed_rows.push_back('{REQ_INSERT, 5'd0,  32'h8000_0000, 1'b1, '{1'b1, 32'h0, 5'd1}});
        directed_rows.push_back('{REQ_INSERT, 5'd1,  32'h7FFF_FFFF, 1'b1, '{1'b1, 32'h0, 5'd2}});
        directed_rows.push_back('{REQ_READ,   5'd0,  32'h0, 1'b1, '{1'b1, 32'h8000_0000, 5'd2}});
        directed_rows.push_back('{REQ_READ,   5'd1,  32'h0, 1'b1, '{1'b1, 32'h7FFF_FFFF, 5'd2}});
        // fill to capacity at mixed positions
        directed_rows.push_back('{REQ_INSERT, 5'd2,  32'h0000_0000, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd0,  32'hFFFF_FFFF, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd3,  32'h5555_5555, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd1,  32'hAAAA_AAAA, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd5,  32'h0000_0001, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd6,  32'hFFFF_FFFE, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd0,  32'h0F0F_0F0F, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd8,  32'hF0F0_F0F0, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd4,  32'h00FF_00FF, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd10, 32'hFF00_FF00, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd11, 32'h3333_3333, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd2,  32'hCCCC_CCCC, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd13, 32'hDEAD_BEEF, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd15, 32'h0BAD_F00D, 1'b0, '0});
        directed_rows.push_back('{REQ_INSERT, 5'd16, 32'h1111_1111, 1'b1, '{1'b0, 32'h0, 5'd16}});
        directed_rows.push_back('{REQ_READ,   5'd31, 32'h0,         1'b1, '{1'b0, 32'h0, 5'd16}});
        directed_rows.push_back('{REQ_READ,   5'd15, 32'h0,         1'b0, '0});
        directed_rows.push_back('{REQ_REMOVE, 5'd0,  32'h0,         1'b0, '0});
        directed_rows.push_back('{REQ_CLEAR,  5'd7,  32'h0,         1'b1, '{1'b1, 32'h0, 5'd0}});
        directed_rows.push_back('{REQ_REMOVE, 5'd0,  32'h0,         1'b1, '{1'b0, 32'h0, 5'd0}});

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].value,
                         directed_rows[i].typed, directed_rows[i].result);

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            phase    = (n / 150) % 3;   // grow, mixed, shrink
            idle_pct = (n >= 700 && n < 1000) ? 0 : 9;
            if (n == 400)
                hold_off_go = 1'b1;
            roll = $urandom_range(99);
            case (phase)
                0:       kind = (roll < 60) ? REQ_INSERT : (roll < 70) ? REQ_REMOVE :
                                (roll < 98) ? REQ_READ : REQ_CLEAR;
                1:       kind = (roll < 35) ? REQ_INSERT : (roll < 60) ? REQ_REMOVE :
                                (roll < 97) ? REQ_READ : REQ_CLEAR;
                default: kind = (roll < 20) ? REQ_INSERT : (roll < 65) ? REQ_REMOVE :
                                (roll < 97) ? REQ_READ : REQ_CLEAR;
            endcase
            // mostly in-range positions, some noise across the whole field
            if ($urandom_range(99) < 10 || kind == REQ_CLEAR)
                pos = POS_W'($urandom_range(31));
            else if (kind == REQ_INSERT)
                pos = POS_W'($urandom_range(list_len));
            else
                pos = (list_len == 0) ? POS_W'($urandom_range(31))
                                      : POS_W'($urandom_range(list_len - 1));
            send_request(kind, pos, pick_value(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* sim.f */
src/plst_pkg.sv
src/plst_cell.sv
src/positional_list_store_top.sv
sim/tb_positional_list_store_top.sv
